FILE: hdl/ledf_pkg.sv
// Shared types and constants for the list-mode event stream deframer.
package ledf_pkg;

  localparam logic [7:0]  FHW_RESET   = 8'd29;
  localparam logic [15:0] BTYPE_RESET = 16'h0002;
  localparam logic [7:0]  HDR_WORDS   = 8'd21;
  localparam logic [7:0]  PAD_WORDS   = 8'd4;
  localparam logic [15:0] EVENT_WORDS = 16'd3;

  localparam int KIND_BIT = 47;
  localparam int AMP_LSB  = 39;
  localparam int Y_LSB    = 29;
  localparam int X_LSB    = 19;

  localparam logic REG_FHW   = 1'b0;
  localparam logic REG_BTYPE = 1'b1;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_HEAD,
    PH_EVENT,
    PH_PAD,
    PH_STOP
  } phase_t;

  typedef struct packed {
    logic [7:0]  file_header_words;
    logic [15:0] expected_buffer_type;
  } cfg_t;

  typedef struct packed {
    logic        event_kind;
    logic [7:0]  amplitude;
    logic [9:0]  y_position;
    logic [9:0]  x_position;
    logic [18:0] event_stamp;
    logic [48:0] absolute_time;
    logic [7:0]  module_id;
    logic [7:0]  module_status;
    logic [47:0] param_zero;
    logic [47:0] param_one;
    logic [47:0] param_two;
    logic [47:0] param_three;
  } result_t;

  typedef struct packed {
    phase_t phase;
    logic   push;
  } status_t;

endpackage

FILE: hdl/ledf_if.sv
// Stream interfaces for the input words and the decoded events.
interface ledf_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface ledf_out_if;
  logic        valid;
  logic        ready;
  logic        event_kind;
  logic [7:0]  amplitude;
  logic [9:0]  y_position;
  logic [9:0]  x_position;
  logic [18:0] event_stamp;
  logic [48:0] absolute_time;
  logic [7:0]  module_id;
  logic [7:0]  module_status;
  logic [47:0] param_zero;
  logic [47:0] param_one;
  logic [47:0] param_two;
  logic [47:0] param_three;

  modport source (
    output valid, input ready,
    output event_kind, output amplitude, output y_position, output x_position,
    output event_stamp, output absolute_time, output module_id, output module_status,
    output param_zero, output param_one, output param_two, output param_three
  );
  modport sink (
    input valid, output ready,
    input event_kind, input amplitude, input y_position, input x_position,
    input event_stamp, input absolute_time, input module_id, input module_status,
    input param_zero, input param_one, input param_two, input param_three
  );
endinterface

FILE: hdl/ledf_cfg.sv
// APB-style register file holding the skip count and the expected buffer type.
module ledf_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output ledf_pkg::cfg_t     cfg
);

  logic [7:0]  fhw_r;
  logic [15:0] btype_r;
  logic        reg_idx;
  logic        wr_en;

  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fhw_r   <= ledf_pkg::FHW_RESET;
      btype_r <= ledf_pkg::BTYPE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        ledf_pkg::REG_FHW:   fhw_r   <= pwdata[7:0];
        ledf_pkg::REG_BTYPE: btype_r <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ledf_pkg::REG_FHW:   prdata = {24'd0, fhw_r};
      ledf_pkg::REG_BTYPE: prdata = {16'd0, btype_r};
    endcase
  end

  assign cfg.file_header_words    = fhw_r;
  assign cfg.expected_buffer_type = btype_r;

endmodule

FILE: hdl/ledf_parse.sv
// Word-by-word parser: file header skip, buffer header capture and event decode.
module ledf_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ledf_pkg::cfg_t       cfg,
  input  logic                 accept,
  input  logic [15:0]          word,
  output ledf_pkg::result_t    result,
  output ledf_pkg::status_t    status
);

  typedef enum logic [2:0] {
    HK_NONE,
    HK_LEN,
    HK_TYPE,
    HK_MOD,
    HK_LOW,
    HK_MID,
    HK_TIME,
    HK_PARAM
  } head_kind_t;

  ledf_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  word_count_r, word_count_nxt;
  logic [15:0] words_left_r, words_left_nxt;
  logic [15:0] buffer_length_r, buffer_length_nxt;
  logic [15:0] partial_low_r, partial_low_nxt;
  logic [15:0] partial_mid_r, partial_mid_nxt;
  logic [47:0] header_time_r;
  logic [7:0]  module_id_r;
  logic [7:0]  status_r;
  logic [47:0] header_params_r [4];

  logic        head_go;
  logic [7:0]  head_idx;
  logic [7:0]  head_cnt;
  head_kind_t  head_kind;
  logic [1:0]  param_idx;
  logic [47:0] joined;
  logic        len_we, mod_we, time_we, param_we;
  logic        push;
  logic [18:0] stamp;

  assign head_go  = (phase_r == ledf_pkg::PH_HEAD) ||
                    ((phase_r == ledf_pkg::PH_SKIP) &&
                     (word_count_r >= cfg.file_header_words));
  assign head_idx = (phase_r == ledf_pkg::PH_SKIP) ? 8'd0 : word_count_r;
  assign head_cnt = head_idx + 8'd1;
  assign joined   = {word, partial_mid_r, partial_low_r};

  always_comb begin
    param_idx = 2'd0;
    unique case (head_idx)
      8'd0:                                head_kind = HK_LEN;
      8'd1:                                head_kind = HK_TYPE;
      8'd5:                                head_kind = HK_MOD;
      8'd6, 8'd9, 8'd12, 8'd15, 8'd18:     head_kind = HK_LOW;
      8'd7, 8'd10, 8'd13, 8'd16, 8'd19:    head_kind = HK_MID;
      8'd8:                                head_kind = HK_TIME;
      8'd11: begin
        head_kind = HK_PARAM;
        param_idx = 2'd0;
      end
      8'd14: begin
        head_kind = HK_PARAM;
        param_idx = 2'd1;
      end
      8'd17: begin
        head_kind = HK_PARAM;
        param_idx = 2'd2;
      end
      8'd20: begin
        head_kind = HK_PARAM;
        param_idx = 2'd3;
      end
      default:                             head_kind = HK_NONE;
    endcase
  end

  // Next-state logic.
  always_comb begin
    phase_nxt         = phase_r;
    word_count_nxt    = word_count_r;
    words_left_nxt    = words_left_r;
    buffer_length_nxt = buffer_length_r;
    partial_low_nxt   = partial_low_r;
    partial_mid_nxt   = partial_mid_r;
    len_we            = 1'b0;
    mod_we            = 1'b0;
    time_we           = 1'b0;
    param_we          = 1'b0;
    if (accept) begin
      priority if (head_go) begin
        if ((head_kind == HK_TYPE) && (word != cfg.expected_buffer_type)) begin
          phase_nxt = ledf_pkg::PH_STOP;
        end else begin
          unique case (head_kind)
            HK_LEN: begin
              buffer_length_nxt = word;
              len_we            = 1'b1;
            end
            HK_MOD:   mod_we          = 1'b1;
            HK_LOW:   partial_low_nxt = word;
            HK_MID:   partial_mid_nxt = word;
            HK_TIME:  time_we         = 1'b1;
            HK_PARAM: param_we        = 1'b1;
            default:  ;
          endcase
          if (head_cnt >= ledf_pkg::HDR_WORDS) begin
            word_count_nxt = 8'd0;
            words_left_nxt = (buffer_length_r >= 16'(ledf_pkg::HDR_WORDS)) ?
                             buffer_length_r - 16'(ledf_pkg::HDR_WORDS) : 16'd0;
            phase_nxt      = (words_left_nxt >= ledf_pkg::EVENT_WORDS) ?
                             ledf_pkg::PH_EVENT : ledf_pkg::PH_PAD;
          end else begin
            word_count_nxt = head_cnt;
            phase_nxt      = ledf_pkg::PH_HEAD;
          end
        end
      end else if (phase_r == ledf_pkg::PH_SKIP) begin
        word_count_nxt = word_count_r + 8'd1;
      end else if (phase_r == ledf_pkg::PH_EVENT) begin
        unique case (word_count_r)
          8'd0: begin
            partial_low_nxt = word;
            word_count_nxt  = 8'd1;
          end
          8'd1: begin
            partial_mid_nxt = word;
            word_count_nxt  = 8'd2;
          end
          default: begin
            word_count_nxt = 8'd0;
            words_left_nxt = words_left_r - ledf_pkg::EVENT_WORDS;
            if (words_left_nxt < ledf_pkg::EVENT_WORDS) begin
              phase_nxt = ledf_pkg::PH_PAD;
            end
          end
        endcase
      end else if (phase_r == ledf_pkg::PH_PAD) begin
        if ((word_count_r + 8'd1) >= ledf_pkg::PAD_WORDS) begin
          word_count_nxt = 8'd0;
          phase_nxt      = ledf_pkg::PH_HEAD;
        end else begin
          word_count_nxt = word_count_r + 8'd1;
        end
      end else begin
        phase_nxt = phase_r;
      end
    end
  end

  // Result logic.
  always_comb begin
    push                 = accept && (phase_r == ledf_pkg::PH_EVENT) && (word_count_r == 8'd2);
    stamp                = joined[18:0];
    result.event_kind    = joined[ledf_pkg::KIND_BIT];
    result.amplitude     = joined[ledf_pkg::AMP_LSB +: 8];
    result.y_position    = joined[ledf_pkg::Y_LSB +: 10];
    result.x_position    = joined[ledf_pkg::X_LSB +: 10];
    result.event_stamp   = stamp;
    result.absolute_time = {1'b0, header_time_r} + {30'd0, stamp};
    result.module_id     = module_id_r;
    result.module_status = status_r;
    result.param_zero    = header_params_r[0];
    result.param_one     = header_params_r[1];
    result.param_two     = header_params_r[2];
    result.param_three   = header_params_r[3];
    status.phase         = phase_r;
    status.push          = push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= ledf_pkg::PH_SKIP;
      word_count_r    <= 8'd0;
      words_left_r    <= 16'd0;
      buffer_length_r <= 16'd0;
      partial_low_r   <= 16'd0;
      partial_mid_r   <= 16'd0;
    end else begin
      phase_r         <= phase_nxt;
      word_count_r    <= word_count_nxt;
      words_left_r    <= words_left_nxt;
      buffer_length_r <= len_we ? buffer_length_nxt : buffer_length_r;
      partial_low_r   <= partial_low_nxt;
      partial_mid_r   <= partial_mid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mod_we) begin
      module_id_r <= word[15:8];
      status_r    <= word[7:0];
    end
    if (time_we) begin
      header_time_r <= joined;
    end
    if (param_we) begin
      header_params_r[param_idx] <= joined;
    end
  end

endmodule

FILE: hdl/ledf_outreg.sv
// Result register with a skid stage so that input words keep flowing under a stall until the skid stage fills.
module ledf_outreg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ledf_pkg::result_t    push_data,
  output logic                 in_ready,
  ledf_out_if.source           out_if
);

  logic               out_valid_r;
  logic               skid_valid_r;
  ledf_pkg::result_t  out_data_r;
  ledf_pkg::result_t  skid_data_r;
  logic               pop;

  assign pop      = out_valid_r && out_if.ready;
  assign in_ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      priority if (skid_valid_r) begin
        if (pop) begin
          skid_valid_r <= 1'b0;
        end
      end else if (push) begin
        if (!out_valid_r || pop) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_r <= push_data;
      end else begin
        skid_data_r <= push_data;
      end
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.event_kind    = out_data_r.event_kind;
  assign out_if.amplitude     = out_data_r.amplitude;
  assign out_if.y_position    = out_data_r.y_position;
  assign out_if.x_position    = out_data_r.x_position;
  assign out_if.event_stamp   = out_data_r.event_stamp;
  assign out_if.absolute_time = out_data_r.absolute_time;
  assign out_if.module_id     = out_data_r.module_id;
  assign out_if.module_status = out_data_r.module_status;
  assign out_if.param_zero    = out_data_r.param_zero;
  assign out_if.param_one     = out_data_r.param_one;
  assign out_if.param_two     = out_data_r.param_two;
  assign out_if.param_three   = out_data_r.param_three;

endmodule

FILE: hdl/listmode_event_stream_deframer_top.sv
// Top level of the list-mode event stream deframer.
//
//   Channel  Direction  Transfer                           Payload
//   in_if    sink       valid && ready                     word
//   out_if   source     valid && ready                     decoded event with header context
//   APB      slave      psel && penable && pwrite (write)  file_header_words, expected_buffer_type
//
// One stream word is taken every cycle while in_if.ready is high; the parser state is updated at the transfer.
// At the transfer of its third word an event is registered for out_if, or in the skid stage while out_if stalls.
// in_if.ready falls only while the skid stage holds a second pending event.
// Reset is synchronous; the configuration registers return to 29 and 2.
module listmode_event_stream_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  ledf_in_if.sink     in_if,
  ledf_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ledf_pkg::cfg_t     cfg;
  ledf_pkg::result_t  result;
  ledf_pkg::status_t  status;
  logic               in_ready;
  logic               accept;

  assign in_if.ready = in_ready;
  assign accept      = in_if.valid && in_ready;

  ledf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ledf_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .accept (accept),
    .word   (in_if.word),
    .result (result),
    .status (status)
  );

  ledf_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (status.push),
    .push_data (result),
    .in_ready  (in_ready),
    .out_if    (out_if)
  );

`ifndef NO_ASSERTIONS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_if.valid |-> in_if.ready)
    else $error("input stalled with no pending event");

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (status.phase == ledf_pkg::PH_STOP) |=> (status.phase == ledf_pkg::PH_STOP))
    else $error("parser left the stopped state without reset");

  a_push_in_event: assert property (@(posedge clk) disable iff (!rst_n)
    status.push |-> (accept && (status.phase == ledf_pkg::PH_EVENT)))
    else $error("event produced outside the event phase");

  a_valid_from_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(accept))
    else $error("event appeared without an input transfer");
`endif

endmodule
